[design/btr_pkg.sv]
// shared types and constants of the bitmap text renderer
// no dependencies; imported by every module of the block
`default_nettype none

package btr_pkg;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 8;
  localparam int LINE_STEP = 9;
  localparam int CHAR_STEP = 6;
  localparam int FONT_ADDR_W = 10;

  localparam logic [6:0] NEWLINE_CODE = 7'd10;

  localparam logic [1:0] WRAP_NONE = 2'd0;
  localparam logic [1:0] WRAP_COL1 = 2'd1;
  localparam logic [1:0] WRAP_ORIGIN = 2'd2;

  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [1:0] wrap_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [15:0] color;
  } job_t;

endpackage

`default_nettype wire

[design/bitmap_text_renderer.sv]
// bitmap text renderer top level: input decode, text cursor, font and raster
// depends on btr_pkg, btr_cfg, btr_font, btr_raster
//
// usage: s_t* carries items; s_tuser is mode (0 loads one font column, 1 renders
// a character). font columns must be loaded before a glyph that uses them is drawn.
// m_t* carries one pixel write per transfer, m_tlast on the final pixel of a glyph.
// the apb port sets origin, color levels and wrap mode; write it only while idle.
// a load, a newline, a stopped or off-font character is taken without holding
// s_tready low. a drawn character holds s_tready low, longer on output stalls:
// font read setup in the read and load states, then one bit per cycle of its
// five 8-bit columns through the column shift register while no stall holds
// the scan, then a flush state to release the held pixel. one pixel is held
// back so the last one can be marked: a pixel goes out the cycle after the next
// set bit is scanned, the final one after the last column.
// when m_tready is low the scan freezes on the next set bit once the output
// register and the held pixel are both full; nothing is lost.
// reset clears cursor, stop flag and handshakes and sets the config registers to
// their defaults; the font memory is not cleared and needs no clearing pass.
`default_nettype none

module bitmap_text_renderer
  import btr_pkg::*;
#(
  parameter int GLYPH_COUNT = 128,
  parameter int SCREEN_WIDTH = 256,
  parameter int SCREEN_HEIGHT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // first_of_string, text_char, font_glyph, font_column, font_bits
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tuser,  // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // pixel_x, pixel_y, pixel_color
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [8:0] GLYPH_LIM = 9'(GLYPH_COUNT);
  localparam logic [8:0] SW_LIM = 9'(SCREEN_WIDTH);
  localparam logic [8:0] COL_LIMIT = 9'(SCREEN_WIDTH - 5);
  localparam logic [7:0] ROW_LIMIT = 8'(SCREEN_HEIGHT - 8);

  cfg_t cfg;
  job_t job;

  logic       mode;
  logic       first_of_string;
  logic [6:0] text_char;
  logic [6:0] font_glyph;
  logic [2:0] font_column;
  logic [7:0] font_bits;

  logic [8:0] cursor_col;
  logic [7:0] cursor_row;
  logic       text_stopped;
  logic [8:0] cursor_col_next;
  logic [7:0] cursor_row_next;
  logic       text_stopped_next;

  logic                   accept;
  logic                   busy;
  logic                   start;
  logic                   font_we;
  logic [FONT_ADDR_W-1:0] waddr_full;
  logic [FONT_ADDR_W-1:0] base_full;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             rd_data;

  logic [8:0] col0;
  logic [7:0] row0;
  logic       stop0;
  logic [8:0] col1;
  logic [8:0] row_sum;
  logic [7:0] row_down;

  assign first_of_string = s_tdata[0];
  assign text_char = s_tdata[7:1];
  assign font_glyph = s_tdata[14:8];
  assign font_column = s_tdata[17:15];
  assign font_bits = s_tdata[25:18];
  assign mode = s_tuser;

  assign s_tready = !busy;
  assign accept = s_tvalid && s_tready;

  assign waddr_full = FONT_ADDR_W'({font_glyph, 2'b00}) + FONT_ADDR_W'(font_glyph) +
                      FONT_ADDR_W'(font_column);
  assign base_full = FONT_ADDR_W'({text_char, 2'b00}) + FONT_ADDR_W'(text_char);
  assign font_we = accept && !mode && ({2'b00, font_glyph} < GLYPH_LIM) &&
                   (font_column < 3'(GLYPH_COLS));

  assign col0 = first_of_string ? {1'b0, cfg.origin_x} : cursor_col;
  assign row0 = first_of_string ? cfg.origin_y : cursor_row;
  assign stop0 = first_of_string ? 1'b0 : text_stopped;
  assign col1 = col0 + 9'(CHAR_STEP);
  assign row_sum = {1'b0, row0} + 9'(LINE_STEP);
  assign row_down = row_sum[8] ? 8'hFF : row_sum[7:0];

  assign start = accept && mode && !stop0 && (text_char != NEWLINE_CODE) &&
                 (row0 < ROW_LIMIT) && ({2'b00, text_char} < GLYPH_LIM);

  assign job.x0 = col0[7:0];
  assign job.y0 = row0;
  assign job.color = {cfg.red_level[7:3], cfg.green_level[7:2], cfg.blue_level[7:3]};

  always_comb begin
    cursor_col_next = col0;
    cursor_row_next = row0;
    text_stopped_next = stop0;
    if (stop0) begin
      text_stopped_next = 1'b1;
    end else if (text_char == NEWLINE_CODE) begin
      cursor_col_next = {1'b0, cfg.origin_x};
      cursor_row_next = row_down;
      text_stopped_next = (row_down >= ROW_LIMIT);
    end else if (row0 >= ROW_LIMIT) begin
      text_stopped_next = 1'b1;
    end else begin
      cursor_col_next = col1;
      if ((col1 >= COL_LIMIT) && (cfg.wrap_mode != WRAP_NONE)) begin
        cursor_col_next = (cfg.wrap_mode == WRAP_COL1) ? 9'd1 : {1'b0, cfg.origin_x};
        cursor_row_next = row_down;
        text_stopped_next = (row_down >= ROW_LIMIT);
      end
      if ((cfg.wrap_mode == WRAP_NONE) && (col1 >= SW_LIM)) begin
        text_stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 9'd0;
      cursor_row <= 8'd0;
      text_stopped <= 1'b0;
    end else if (accept && mode) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      text_stopped <= text_stopped_next;
    end
  end

  btr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  btr_font #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (AW'(waddr_full)),
    .wdata (font_bits),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  btr_raster #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .AW           (AW)
  ) u_raster (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .job      (job),
    .base     (AW'(base_full)),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[design/btr_cfg.sv]
// register file behind the apb port: origin, color levels, wrap mode
// depends on btr_pkg
`default_nettype none

module btr_cfg
  import btr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_RED,
    REG_GREEN,
    REG_BLUE,
    REG_WRAP
  } reg_idx_t;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= 8'd0;
      cfg.origin_y <= 8'd0;
      cfg.red_level <= 8'hFF;
      cfg.green_level <= 8'hFF;
      cfg.blue_level <= 8'hFF;
      cfg.wrap_mode <= WRAP_NONE;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X: cfg.origin_x <= pwdata[7:0];
        REG_ORIGIN_Y: cfg.origin_y <= pwdata[7:0];
        REG_RED:      cfg.red_level <= pwdata[7:0];
        REG_GREEN:    cfg.green_level <= pwdata[7:0];
        REG_BLUE:     cfg.blue_level <= pwdata[7:0];
        REG_WRAP:     cfg.wrap_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X: prdata = {24'd0, cfg.origin_x};
      REG_ORIGIN_Y: prdata = {24'd0, cfg.origin_y};
      REG_RED:      prdata = {24'd0, cfg.red_level};
      REG_GREEN:    prdata = {24'd0, cfg.green_level};
      REG_BLUE:     prdata = {24'd0, cfg.blue_level};
      REG_WRAP:     prdata = {30'd0, cfg.wrap_mode};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/btr_font.sv]
// font memory: one byte per glyph column, one write and one registered read port
// depends on btr_pkg
`default_nettype none

module btr_font
  import btr_pkg::*;
#(
  parameter int DEPTH = 640,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/btr_raster.sv]
// glyph rasterizer: shifts each font column out one bit per cycle unless
// stalled; one pixel per on-screen set bit; uses btr_pkg and btr_font data
`default_nettype none

module btr_raster
  import btr_pkg::*;
#(
  parameter int SCREEN_WIDTH = 256,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire job_t          job,
  input  wire logic [AW-1:0] base,
  output logic               busy,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [7:0]    rd_data,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [31:0]        m_tdata,  // pixel_x, pixel_y, pixel_color
  output logic               m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SHIFT,
    ST_FLUSH
  } state_t;

  localparam logic [8:0] SW_LIM = 9'(SCREEN_WIDTH);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

  state_t        state;
  logic [7:0]    x0;
  logic [7:0]    y0;
  logic [15:0]   color;
  logic [AW-1:0] addr;
  logic [2:0]    col_i;
  logic [2:0]    row_j;
  logic [7:0]    sh;
  logic          pend_valid;
  logic [7:0]    pend_x;
  logic [7:0]    pend_y;
  logic [7:0]    out_x;
  logic [7:0]    out_y;
  logic [15:0]   out_color;

  logic [8:0] px;
  logic [8:0] py;
  logic       hit;
  logic       out_free;
  logic       stall;

  assign px = {1'b0, x0} + {6'd0, col_i};
  assign py = {1'b0, y0} + {6'd0, row_j};
  assign hit = sh[7] && (px < SW_LIM) && !py[8];
  assign out_free = !m_tvalid || m_tready;
  assign stall = hit && pend_valid && !out_free;

  assign busy = (state != ST_IDLE);
  assign rd_addr = addr;
  assign rd_en = (state == ST_READ) || (state == ST_LOAD) ||
                 ((state == ST_SHIFT) && !stall && (row_j == LAST_ROW) &&
                  (col_i < LAST_COL - 3'd1));
  assign m_tdata = {out_color, out_y, out_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            x0 <= job.x0;
            y0 <= job.y0;
            color <= job.color;
            addr <= base;
            col_i <= 3'd0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          addr <= addr + 1'b1;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          sh <= rd_data;
          row_j <= 3'd0;
          addr <= addr + 1'b1;
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!stall) begin
            if (hit) begin
              if (pend_valid) begin
                out_x <= pend_x;
                out_y <= pend_y;
                out_color <= color;
                m_tlast <= 1'b0;
                m_tvalid <= 1'b1;
              end
              pend_x <= px[7:0];
              pend_y <= py[7:0];
              pend_valid <= 1'b1;
            end
            sh <= {sh[6:0], 1'b0};
            row_j <= row_j + 1'b1;
            if (row_j == LAST_ROW) begin
              if (col_i == LAST_COL) begin
                state <= ST_FLUSH;
              end else begin
                col_i <= col_i + 1'b1;
                sh <= rd_data;
                if (col_i < LAST_COL - 3'd1) begin
                  addr <= addr + 1'b1;
                end
              end
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_x <= pend_x;
            out_y <= pend_y;
            out_color <= color;
            m_tlast <= 1'b1;
            m_tvalid <= 1'b1;
            pend_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending pixel left behind after glyph end");

  a_stall_holds_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SHIFT) && stall) |=> ($stable(row_j) && $stable(col_i) && $stable(sh)))
    else $error("scan moved while output stage was full");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (col_i <= LAST_COL))
    else $error("column counter out of glyph");

  a_last_only_flush: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SHIFT) && hit && pend_valid && out_free) |=> (m_tvalid && !m_tlast))
    else $error("mid-glyph pixel marked last");

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for bitmap_text_renderer: font loads and text strings sent over the stream port
// predicts each pixel transfer from its own font store, cursor and register copies
// depends on btr_pkg and the bitmap_text_renderer design
`timescale 1ns / 1ps

module testbench;
  import btr_pkg::*;

  localparam int GLYPH_COUNT = 128;
  localparam int SCREEN_WIDTH = 256;
  localparam int SCREEN_HEIGHT = 128;
  localparam int ROW_LIMIT = SCREEN_HEIGHT - 8;
  localparam int COL_LIMIT = SCREEN_WIDTH - 5;
  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_COLS;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam int REG_ORIGIN_X = 0;
  localparam int REG_ORIGIN_Y = 1;
  localparam int REG_RED = 2;
  localparam int REG_GREEN = 3;
  localparam int REG_BLUE = 4;
  localparam int REG_WRAP = 5;

  typedef struct packed {
    logic       mode;
    logic       first;
    logic [6:0] ch;
    logic [6:0] glyph;
    logic [2:0] column;
    logic [7:0] bits;
  } text_item_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bitmap_text_renderer #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // register copies
  logic [7:0] org_x = 8'd0;
  logic [7:0] org_y = 8'd0;
  logic [7:0] red_lvl = 8'd255;
  logic [7:0] green_lvl = 8'd255;
  logic [7:0] blue_lvl = 8'd255;
  logic [1:0] wrap_sel = WRAP_NONE;

  // font and cursor copies
  logic [7:0] font_mem [0:FONT_DEPTH-1];
  bit         font_written [0:FONT_DEPTH-1];
  bit         glyph_listed [0:GLYPH_COUNT-1];
  int         usable_glyphs [$];
  int         cur_col = 0;
  int         cur_row = 0;
  bit         text_stopped = 1'b0;

  pixel_t     pixel_queue [$];
  int         errors = 0;
  int         cycle_count = 0;
  int         hold_len = 0;
  bit         steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void note_usable(input int glyph);
    int  c;
    bit  full;
    full = 1'b1;
    for (c = 0; c < GLYPH_COLS; c++)
      if (!font_written[glyph * GLYPH_COLS + c]) full = 1'b0;
    if (full && !glyph_listed[glyph] && glyph != NEWLINE_CODE) begin
      glyph_listed[glyph] = 1'b1;
      usable_glyphs.push_back(glyph);
    end
  endfunction

  function automatic void line_down();
    cur_row = cur_row + LINE_STEP;
    if (cur_row > 255) cur_row = 255;
    if (cur_row >= ROW_LIMIT) text_stopped = 1'b1;
  endfunction

  function automatic void predict_pixels(input text_item_t it);
    int          base;
    int          col;
    int          row;
    int          px;
    int          py;
    logic [7:0]  colbits;
    logic [15:0] color;
    pixel_t      held;
    bit          have_held;
    have_held = 1'b0;
    held = '0;
    if (it.mode == MODE_LOAD) begin
      if (it.column < GLYPH_COLS) begin
        base = int'(it.glyph) * GLYPH_COLS + int'(it.column);
        font_mem[base] = it.bits;
        font_written[base] = 1'b1;
        note_usable(int'(it.glyph));
      end
      return;
    end
    if (it.first) begin
      cur_col = int'(org_x);
      cur_row = int'(org_y);
      text_stopped = 1'b0;
    end
    if (text_stopped) return;
    if (it.ch == NEWLINE_CODE) begin
      cur_col = int'(org_x);
      line_down();
      return;
    end
    if (cur_row >= ROW_LIMIT) begin
      text_stopped = 1'b1;
      return;
    end
    color = {red_lvl[7:3], green_lvl[7:2], blue_lvl[7:3]};
    base = int'(it.ch) * GLYPH_COLS;
    for (col = 0; col < GLYPH_COLS; col++) begin
      colbits = font_mem[base + col];
      px = cur_col + col;
      if (px < SCREEN_WIDTH) begin
        for (row = 0; row < GLYPH_ROWS; row++) begin
          py = cur_row + row;
          if (colbits[7 - row] && py <= 255) begin
            if (have_held) pixel_queue.push_back(held);
            held.x = 8'(px);
            held.y = 8'(py);
            held.color = color;
            held.last = 1'b0;
            have_held = 1'b1;
          end
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pixel_queue.push_back(held);
    end
    cur_col = cur_col + CHAR_STEP;
    if (cur_col >= COL_LIMIT && wrap_sel != WRAP_NONE) begin
      cur_col = (wrap_sel == WRAP_COL1) ? 1 : int'(org_x);
      line_down();
    end
    if (cur_row >= ROW_LIMIT) text_stopped = 1'b1;
    if (wrap_sel == WRAP_NONE && cur_col >= SCREEN_WIDTH) text_stopped = 1'b1;
    cur_col = cur_col & 'h1FF;
  endfunction

  task automatic send_item(input text_item_t it);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.mode;
    s_tdata <= {6'd0, it.bits, it.column, it.glyph, it.ch, it.first};
    do @(posedge clk); while (!s_tready);
    predict_pixels(it);
  endtask

  task automatic send_load(input int glyph, input int column, input logic [7:0] bits);
    text_item_t it;
    it.mode = MODE_LOAD;
    it.first = 1'($urandom_range(0, 1));
    it.ch = 7'($urandom_range(0, 127));
    it.glyph = 7'(glyph);
    it.column = 3'(column);
    it.bits = bits;
    send_item(it);
  endtask

  task automatic send_char(input logic first, input logic [6:0] ch);
    text_item_t it;
    it.mode = MODE_DRAW;
    it.first = first;
    it.ch = ch;
    it.glyph = 7'($urandom_range(0, 127));
    it.column = 3'($urandom_range(0, 7));
    it.bits = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic load_glyph(input int glyph, input logic [39:0] cols);
    int c;
    for (c = 0; c < GLYPH_COLS; c++) send_load(glyph, c, cols[8*c +: 8]);
  endtask

  function automatic logic [7:0] random_column();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [6:0] any_glyph();
    return 7'(usable_glyphs[$urandom_range(0, usable_glyphs.size() - 1)]);
  endfunction

  task automatic send_string(input int len);
    int k;
    send_char(1'b1, any_glyph());
    for (k = 1; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) send_char(1'b0, NEWLINE_CODE);
      else send_char(1'b0, any_glyph());
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(index * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_ORIGIN_X: org_x = value[7:0];
      REG_ORIGIN_Y: org_y = value[7:0];
      REG_RED:      red_lvl = value[7:0];
      REG_GREEN:    green_lvl = value[7:0];
      REG_BLUE:     blue_lvl = value[7:0];
      REG_WRAP:     wrap_sel = value[1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] ox, input logic [7:0] oy, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [1:0] wrap);
    wait_drained();
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_RED, 32'(r));
    write_reg(REG_GREEN, 32'(g));
    write_reg(REG_BLUE, 32'(b));
    write_reg(REG_WRAP, 32'(wrap));
  endtask

  task automatic test_font_load();
    load_glyph(0, 40'hAA_00_01_80_FF);
    load_glyph(127, 40'hFF_3C_C3_FF_55);
    load_glyph(1, 40'h00_00_00_00_00);
    // out of range columns must not alias into the next glyph
    send_load(0, 5, 8'hFF);
    send_load(127, 7, 8'hFF);
  endtask

  task automatic test_directed_text();
    send_char(1'b1, 7'd0);
    send_char(1'b0, 7'd127);
    send_char(1'b0, NEWLINE_CODE);
    send_char(1'b0, 7'd1);
    send_char(1'b0, 7'd0);
    // right edge clipping, then no-wrap overflow stops the text
    configure(8'd253, 8'd0, 8'h00, 8'hFF, 8'h07, WRAP_NONE);
    send_char(1'b1, 7'd127);
    send_char(1'b0, 7'd0);
    // row limit reached by a newline
    configure(8'd0, 8'd115, 8'hF8, 8'h03, 8'hFF, WRAP_COL1);
    send_char(1'b1, 7'd0);
    send_char(1'b0, NEWLINE_CODE);
    send_char(1'b0, 7'd0);
    // origin already past the row limit
    configure(8'd250, 8'd255, 8'h80, 8'h80, 8'h80, WRAP_ORIGIN);
    send_char(1'b1, 7'd127);
  endtask

  task automatic test_random_text();
    int phase;
    int sent;
    int sel;
    int len;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, WRAP_NONE);
        1: configure(8'd255, 8'd100, 8'd255, 8'd255, 8'd255, WRAP_COL1);
        2: configure(8'd200, 8'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), WRAP_ORIGIN);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 110)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 2'($urandom_range(0, 2)));
      endcase
      sent = 0;
      while (sent < 34) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          load_glyph($urandom_range(0, 127), {random_column(), random_column(),
                     random_column(), random_column(), random_column()});
          sent += GLYPH_COLS;
        end else if (sel < 22) begin
          if ($urandom_range(0, 1))
            send_load($urandom_range(0, 127), $urandom_range(GLYPH_COLS, 7),
                      8'($urandom_range(0, 255)));
          else
            send_char(1'b0, any_glyph());
          sent++;
        end else begin
          len = $urandom_range(2, 10);
          send_string(len);
          sent += len;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    int k;
    configure(8'd3, 8'd10, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), WRAP_COL1);
    hold_len = HOLD_CYCLES;
    for (k = 0; k < 14; k++) send_char(k == 0, (k % 2) ? 7'd127 : 7'd0);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    send_string(6);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pixel_queue.size() != 0);
    send_char(1'b0, any_glyph());
    send_string(5);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    int sent;
    int len;
    steady = 1'b1;
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 2'($urandom_range(0, 2)));
    sent = 0;
    while (sent < 40) begin
      len = $urandom_range(5, 10);
      send_string(len);
      sent += len;
    end
  endtask

  // output ready: random stalls, or a long hold when one is requested
  initial begin : ready_gen
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        m_tready <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_queue.size() == 0) begin
        $error("pixel transfer with none expected: x=%0d y=%0d", m_tdata[7:0], m_tdata[15:8]);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (m_tdata[7:0] !== want.x) begin
          $error("pixel_x expected %0d got %0d", want.x, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[15:8] !== want.y) begin
          $error("pixel_y expected %0d got %0d", want.y, m_tdata[15:8]);
          errors++;
        end
        if (m_tdata[31:16] !== want.color) begin
          $error("pixel_color expected %h got %h", want.color, m_tdata[31:16]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_pixel expected %0d got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : main_seq
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_font_load();
    test_directed_text();
    test_random_text();
    test_output_backpressure();
    test_sender_pause();
    test_steady_stream();
    wait_drained();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
design/btr_pkg.sv
design/btr_cfg.sv
design/btr_font.sv
design/btr_raster.sv
design/bitmap_text_renderer.sv
verif/testbench.sv
